### design/dps_pkg.sv
package dps_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned SumW    = 32;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_SPEED_KP   = 3'd0,
    REG_SPEED_KI   = 3'd1,
    REG_SPEED_KD   = 3'd2,
    REG_HEADING_KP = 3'd3,
    REG_HEADING_KI = 3'd4,
    REG_HEADING_KD = 3'd5,
    REG_STEER_LIM  = 3'd6,
    REG_THROT_LIM  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] measured_speed;
    logic signed [DataW-1:0] measured_heading;
    logic signed [DataW-1:0] goal_speed;
    logic signed [DataW-1:0] goal_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] steer_out;
    logic signed [DataW-1:0] throttle_out;
    logic signed [DataW-1:0] speed_err_out;
    logic signed [DataW-1:0] heading_err_out;
  } out_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] speed_kp;
    logic signed [DataW-1:0] speed_ki;
    logic signed [DataW-1:0] speed_kd;
    logic signed [DataW-1:0] heading_kp;
    logic signed [DataW-1:0] heading_ki;
    logic signed [DataW-1:0] heading_kd;
    logic [LimitW-1:0]       steer_limit;
    logic [LimitW-1:0]       throttle_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] speed_err;
    logic signed [DataW-1:0] heading_err;
    logic signed [DataW:0]   speed_diff;
    logic signed [DataW:0]   heading_diff;
    logic signed [SumW-1:0]  speed_sum;
    logic signed [SumW-1:0]  heading_sum;
    logic                    use_d;
  } err_t;

  localparam logic [LimitW-1:0] LimitReset = '1;

  function automatic logic signed [DataW-1:0] sat_data(logic signed [DataW:0] v);
    logic signed [DataW-1:0] r;
    if (v[DataW] != v[DataW-1]) begin
      r = v[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SumW-1:0] sat_sum(logic signed [SumW:0] v);
    logic signed [SumW-1:0] r;
    if (v[SumW] != v[SumW-1]) begin
      r = v[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

endpackage

### design/dual_pid_speed_heading.sv
// Path from input accept to result valid: input register, error/accumulator stage,
//   multiply/round/clamp into the output register.
// Throughput: one item per cycle while out_ready_i does not stall; each stage advances when the next is free.
// Reset: pipeline empty, accumulators and previous errors zero, first item has
//   no derivative term, gains zero, steer and throttle limits 32767.
module dual_pid_speed_heading (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dps_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [dps_pkg::DataW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dps_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dps_pkg::out_item_t          out_item_o
);
  import dps_pkg::*;

  cfg_t      cfg;
  in_item_t  s0_q;
  err_t      s1_q, s1_d;
  out_item_t out_q, out_d;
  logic      s0_v_q, s1_v_q, out_v_q;
  logic      s0_en, s1_en, out_en;
  logic signed [DataW-1:0] thr, steer;

  assign out_en = !out_v_q || out_ready_i;
  assign s1_en  = !s1_v_q || out_en;
  assign s0_en  = !s0_v_q || s1_en;

  assign in_ready_o  = s0_en;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  dps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dps_err_stage u_err (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_en && s0_v_q),
    .item_i (s0_q),
    .err_o  (s1_d)
  );

  dps_pid_term u_throttle (
    .err_i   (s1_q.speed_err),
    .sum_i   (s1_q.speed_sum),
    .diff_i  (s1_q.speed_diff),
    .use_d_i (s1_q.use_d),
    .kp_i    (cfg.speed_kp),
    .ki_i    (cfg.speed_ki),
    .kd_i    (cfg.speed_kd),
    .limit_i (cfg.throttle_limit),
    .out_o   (thr)
  );

  dps_pid_term u_steer (
    .err_i   (s1_q.heading_err),
    .sum_i   (s1_q.heading_sum),
    .diff_i  (s1_q.heading_diff),
    .use_d_i (s1_q.use_d),
    .kp_i    (cfg.heading_kp),
    .ki_i    (cfg.heading_ki),
    .kd_i    (cfg.heading_kd),
    .limit_i (cfg.steer_limit),
    .out_o   (steer)
  );

  always_comb begin
    out_d.steer_out       = steer;
    out_d.throttle_out    = thr;
    out_d.speed_err_out   = s1_q.speed_err;
    out_d.heading_err_out = s1_q.heading_err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s0_en)  s0_v_q  <= in_valid_i;
      if (s1_en)  s1_v_q  <= s0_v_q;
      if (out_en) out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_en && in_valid_i) s0_q  <= in_item_i;
    if (s1_en && s0_v_q)     s1_q  <= s1_d;
    if (out_en && s1_v_q)    out_q <= out_d;
  end

  logic signed [DataW:0] thr_lim, steer_lim;
  assign thr_lim   = $signed({2'b00, cfg.throttle_limit});
  assign steer_lim = $signed({2'b00, cfg.steer_limit});

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_v_q |-> in_ready_o)
    else $error("input stage empty but not ready");

  a_throttle_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((DataW+1)'(out_q.throttle_out) <= thr_lim) &&
                ((DataW+1)'(out_q.throttle_out) >= -thr_lim))
    else $error("throttle exceeds limit");

  a_steer_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((DataW+1)'(out_q.steer_out) <= steer_lim) &&
                ((DataW+1)'(out_q.steer_out) >= -steer_lim))
    else $error("steering exceeds limit");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_en) |=> s1_v_q && $stable(s1_q))
    else $error("stalled stage lost its item");

endmodule

### design/dps_cfg_regs.sv
module dps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dps_pkg::RegIdxW-1:0]    cfg_idx_i,
  input  logic [dps_pkg::DataW-1:0]      cfg_wdata_i,
  output dps_pkg::cfg_t                  cfg_o
);
  import dps_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SPEED_KP:   cfg_d.speed_kp       = cfg_wdata_i;
        REG_SPEED_KI:   cfg_d.speed_ki       = cfg_wdata_i;
        REG_SPEED_KD:   cfg_d.speed_kd       = cfg_wdata_i;
        REG_HEADING_KP: cfg_d.heading_kp     = cfg_wdata_i;
        REG_HEADING_KI: cfg_d.heading_ki     = cfg_wdata_i;
        REG_HEADING_KD: cfg_d.heading_kd     = cfg_wdata_i;
        REG_STEER_LIM:  cfg_d.steer_limit    = cfg_wdata_i[LimitW-1:0];
        REG_THROT_LIM:  cfg_d.throttle_limit = cfg_wdata_i[LimitW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= {{(6*DataW){1'b0}}, LimitReset, LimitReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/dps_err_stage.sv
module dps_err_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  dps_pkg::in_item_t item_i,
  output dps_pkg::err_t     err_o
);
  import dps_pkg::*;

  logic signed [SumW-1:0]  speed_sum_q, heading_sum_q;
  logic signed [DataW-1:0] prev_speed_q, prev_heading_q;
  logic                    have_prev_q;

  logic signed [DataW-1:0] speed_err, heading_err;
  logic signed [SumW-1:0]  speed_sum_d, heading_sum_d;

  assign speed_err   = sat_data({item_i.goal_speed[DataW-1], item_i.goal_speed}
                              - {item_i.measured_speed[DataW-1], item_i.measured_speed});
  assign heading_err = sat_data({item_i.goal_heading[DataW-1], item_i.goal_heading}
                              - {item_i.measured_heading[DataW-1], item_i.measured_heading});

  assign speed_sum_d   = sat_sum({speed_sum_q[SumW-1], speed_sum_q}
                                 + (SumW+1)'(speed_err));
  assign heading_sum_d = sat_sum({heading_sum_q[SumW-1], heading_sum_q}
                                 + (SumW+1)'(heading_err));

  always_comb begin
    err_o.speed_err    = speed_err;
    err_o.heading_err  = heading_err;
    err_o.speed_diff   = {speed_err[DataW-1], speed_err}
                       - {prev_speed_q[DataW-1], prev_speed_q};
    err_o.heading_diff = {heading_err[DataW-1], heading_err}
                       - {prev_heading_q[DataW-1], prev_heading_q};
    err_o.speed_sum    = speed_sum_d;
    err_o.heading_sum  = heading_sum_d;
    err_o.use_d        = have_prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_sum_q    <= '0;
      heading_sum_q  <= '0;
      prev_speed_q   <= '0;
      prev_heading_q <= '0;
      have_prev_q    <= 1'b0;
    end else if (load_i) begin
      speed_sum_q    <= speed_sum_d;
      heading_sum_q  <= heading_sum_d;
      prev_speed_q   <= speed_err;
      prev_heading_q <= heading_err;
      have_prev_q    <= 1'b1;
    end
  end

endmodule

### design/dps_pid_term.sv
module dps_pid_term (
  input  logic signed [dps_pkg::DataW-1:0] err_i,
  input  logic signed [dps_pkg::SumW-1:0]  sum_i,
  input  logic signed [dps_pkg::DataW:0]   diff_i,
  input  logic                             use_d_i,
  input  logic signed [dps_pkg::DataW-1:0] kp_i,
  input  logic signed [dps_pkg::DataW-1:0] ki_i,
  input  logic signed [dps_pkg::DataW-1:0] kd_i,
  input  logic [dps_pkg::LimitW-1:0]       limit_i,
  output logic signed [dps_pkg::DataW-1:0] out_o
);
  import dps_pkg::*;

  localparam int unsigned PW   = 2 * DataW;
  localparam int unsigned IW   = DataW + SumW;
  localparam int unsigned DW   = 2 * DataW + 1;
  localparam int unsigned TotW = IW + 2;
  localparam int unsigned ShW  = TotW - 8;

  logic signed [PW-1:0]   p_prod;
  logic signed [IW-1:0]   i_prod;
  logic signed [DW-1:0]   d_full;
  logic signed [DW-1:0]   d_prod;
  logic signed [TotW-1:0] total;
  logic signed [ShW-1:0]  rounded;
  logic signed [ShW-1:0]  lim_pos, lim_neg;
  logic signed [ShW-1:0]  clamped;

  assign p_prod = kp_i * err_i;
  assign i_prod = ki_i * sum_i;
  assign d_full = kd_i * diff_i;
  assign d_prod = use_d_i ? d_full : '0;

  // round half up from the Q8.8 gain scale to integer: add half LSB then floor shift
  assign total   = TotW'(p_prod) + TotW'(i_prod) + TotW'(d_prod) + TotW'(128);
  assign rounded = total[TotW-1:8];

  assign lim_pos = ShW'($signed({1'b0, limit_i}));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (rounded > lim_pos) begin
      clamped = lim_pos;
    end else if (rounded < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = rounded;
    end
  end

  assign out_o = clamped[DataW-1:0];

endmodule

### bench/dual_pid_speed_heading_test.sv
`timescale 1ns / 100ps

module dual_pid_speed_heading_test;
  import dps_pkg::*;

  typedef logic [DataW-1:0] reg_bank_t [8];

  typedef enum int {
    SET_MODERATE,
    SET_MAX_GAINS,
    SET_MIN_GAINS,
    SET_WIDE,
    SET_TIGHT_LIMIT,
    SET_WIDE_LIMIT
  } setting_e;

  localparam longint SumMax = (longint'(1) <<< (SumW - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;
  localparam longint ErrMax = (longint'(1) <<< (DataW - 1)) - 1;
  localparam longint ErrMin = -ErrMax - 1;

  class pid_pair_model;
    reg_bank_t regs;
    logic signed [SumW-1:0]  speed_sum;
    logic signed [SumW-1:0]  heading_sum;
    logic signed [DataW-1:0] last_speed_err;
    logic signed [DataW-1:0] last_heading_err;
    bit                      have_last;
    out_item_t               due_cmds[$];
    int                      mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      regs[REG_STEER_LIM] = {1'b0, LimitReset};
      regs[REG_THROT_LIM] = {1'b0, LimitReset};
      speed_sum        = '0;
      heading_sum      = '0;
      last_speed_err   = '0;
      last_heading_err = '0;
      have_last        = 1'b0;
      mismatches       = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DataW-1:0] data);
      if (idx == REG_STEER_LIM || idx == REG_THROT_LIM) begin
        regs[idx] = {1'b0, data[LimitW-1:0]};
      end else begin
        regs[idx] = data;
      end
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function logic [DataW-1:0] loop_cmd(longint err, longint sum, longint prev,
                                        reg_idx_e kp, reg_idx_e ki, reg_idx_e kd,
                                        reg_idx_e lim);
      longint total;
      longint limit;
      total = longint'($signed(regs[kp])) * err + longint'($signed(regs[ki])) * sum;
      if (have_last) begin
        total += longint'($signed(regs[kd])) * (err - prev);
      end
      total = (total + 128) >>> 8;
      limit = longint'(regs[lim]);
      total = clip(total, -limit, limit);
      return total[DataW-1:0];
    endfunction

    function void note_sample(in_item_t s);
      longint    es;
      longint    eh;
      out_item_t cmd;
      es = clip(longint'($signed(s.goal_speed)) - longint'($signed(s.measured_speed)),
                ErrMin, ErrMax);
      eh = clip(longint'($signed(s.goal_heading)) - longint'($signed(s.measured_heading)),
                ErrMin, ErrMax);
      speed_sum   = SumW'(clip(longint'(speed_sum) + es, SumMin, SumMax));
      heading_sum = SumW'(clip(longint'(heading_sum) + eh, SumMin, SumMax));
      cmd.steer_out = loop_cmd(eh, longint'(heading_sum), longint'(last_heading_err),
                               REG_HEADING_KP, REG_HEADING_KI, REG_HEADING_KD,
                               REG_STEER_LIM);
      cmd.throttle_out = loop_cmd(es, longint'(speed_sum), longint'(last_speed_err),
                                  REG_SPEED_KP, REG_SPEED_KI, REG_SPEED_KD,
                                  REG_THROT_LIM);
      cmd.speed_err_out   = es[DataW-1:0];
      cmd.heading_err_out = eh[DataW-1:0];
      last_speed_err   = es[DataW-1:0];
      last_heading_err = eh[DataW-1:0];
      have_last        = 1'b1;
      due_cmds.insert(due_cmds.size(), cmd);
    endfunction

    function void check_field(string field, logic [DataW-1:0] want, logic [DataW-1:0] got);
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("mismatch %s: expected %0d, got %0d", field, $signed(want), $signed(got));
        end
        mismatches++;
      end
    endfunction

    function void check_cmd(out_item_t got);
      out_item_t want;
      if (due_cmds.size() == 0) begin
        if (mismatches < 10) begin
          $display("result with no item pending: %h", got);
        end
        mismatches++;
        return;
      end
      want = due_cmds.pop_front();
      check_field("steer_out", want.steer_out, got.steer_out);
      check_field("throttle_out", want.throttle_out, got.throttle_out);
      check_field("speed_err_out", want.speed_err_out, got.speed_err_out);
      check_field("heading_err_out", want.heading_err_out, got.heading_err_out);
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx   = '0;
  logic [DataW-1:0]    cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;

  bit send_idle = 1'b0;
  bit take_idle = 1'b0;
  int hold_len  = 0;

  pid_pair_model cmd_model = new();

  dual_pid_speed_heading uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return DataW'($urandom());
      default: return DataW'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic in_item_t random_sample();
    in_item_t s;
    s.goal_speed   = pick_value();
    s.goal_heading = pick_value();
    if ($urandom_range(0, 1) == 1) begin
      // measurement tracking its goal
      s.measured_speed   = s.goal_speed + DataW'(int'($urandom_range(0, 511)) - 256);
      s.measured_heading = s.goal_heading + DataW'(int'($urandom_range(0, 511)) - 256);
    end else begin
      s.measured_speed   = pick_value();
      s.measured_heading = pick_value();
    end
    return s;
  endfunction

  function automatic reg_bank_t make_bank(setting_e kind);
    reg_bank_t bank;
    for (int i = 0; i < int'(REG_STEER_LIM); i++) begin
      case (kind)
        SET_MAX_GAINS: bank[i] = 16'h7fff;
        SET_MIN_GAINS: bank[i] = 16'h8000;
        SET_WIDE:      bank[i] = DataW'($urandom());
        default:       bank[i] = DataW'(int'($urandom_range(0, 1024)) - 512);
      endcase
    end
    case (kind)
      SET_MAX_GAINS: begin
        bank[REG_STEER_LIM] = 16'h7fff;
        bank[REG_THROT_LIM] = 16'h7fff;
      end
      SET_MIN_GAINS: begin
        bank[REG_STEER_LIM] = 16'h0000;
        bank[REG_THROT_LIM] = 16'h0000;
      end
      SET_TIGHT_LIMIT: begin
        bank[REG_STEER_LIM] = DataW'($urandom_range(0, 255));
        bank[REG_THROT_LIM] = DataW'($urandom_range(0, 255));
      end
      SET_WIDE_LIMIT: begin
        bank[REG_STEER_LIM] = 16'hffff;
        bank[REG_THROT_LIM] = 16'hffff;
      end
      default: begin
        bank[REG_STEER_LIM] = DataW'($urandom());
        bank[REG_THROT_LIM] = DataW'($urandom());
      end
    endcase
    return bank;
  endfunction

  task automatic apply_settings(reg_bank_t bank, bit [7:0] which);
    for (int i = 0; i < 8; i++) begin
      if (which[i]) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= reg_idx_e'(i);
        cfg_wdata <= bank[i];
        @(posedge clk);
        cmd_model.write_reg(reg_idx_e'(i), bank[i]);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(in_item_t s);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (!in_ready);
    cmd_model.note_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (cmd_model.due_cmds.size() != 0);
  endtask

  task automatic run_phase(setting_e kind, int count);
    apply_settings(make_bank(kind), 8'hff);
    for (int i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        send_idle = $urandom_range(0, 2) != 0;
        take_idle = $urandom_range(0, 2) != 0;
      end
      if (kind == SET_MODERATE && i == 30) begin
        send_idle = 1'b0;
        hold_len  = 40;
      end
      if (kind == SET_MODERATE && i == 80) begin
        drain();
      end
      send_item(random_sample());
    end
    drain();
  endtask

  // result side
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = take_idle ? $urandom_range(0, 6) : 0;
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      cmd_model.check_cmd(out_item);
    end
  end

  initial begin
    reg_bank_t bank;
    setting_e  plan[6];
    plan = '{SET_MODERATE, SET_MAX_GAINS, SET_MIN_GAINS, SET_WIDE, SET_TIGHT_LIMIT,
             SET_WIDE_LIMIT};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // limits stay at reset values; derivative gains nonzero for the first sample
    bank = make_bank(SET_MODERATE);
    bank[REG_SPEED_KD]   = 16'h0180;
    bank[REG_HEADING_KD] = 16'hfe80;
    apply_settings(bank, 8'h3f);

    send_item(in_item_t'{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_item(in_item_t'{16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    send_item(in_item_t'{16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
    send_item(in_item_t'{16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    send_item(in_item_t'{16'h8000, 16'h0001, 16'hffff, 16'h8000});
    send_item(in_item_t'{16'h0001, 16'h8000, 16'h8000, 16'hffff});
    send_item(in_item_t'{16'hffff, 16'h0000, 16'h0000, 16'hffff});
    send_item(in_item_t'{16'h5555, 16'haaaa, 16'haaaa, 16'h5555});
    send_item(in_item_t'{16'haaaa, 16'h5555, 16'h5555, 16'haaaa});
    send_item(in_item_t'{16'h0000, 16'h0000, 16'h0100, 16'hff00});
    send_item(in_item_t'{16'h8000, 16'h8000, 16'h8000, 16'h8000});
    send_item(in_item_t'{16'h0080, 16'hff80, 16'h0000, 16'h0000});
    drain();

    foreach (plan[p]) begin
      run_phase(plan[p], 105);
    end

    // push the two integrators hard in opposite directions, then back
    bank = make_bank(SET_MODERATE);
    bank[REG_SPEED_KI]   = 16'h0001;
    bank[REG_HEADING_KI] = 16'h0001;
    bank[REG_STEER_LIM]  = 16'h7fff;
    bank[REG_THROT_LIM]  = 16'h7fff;
    apply_settings(bank, 8'hff);
    send_idle = 1'b0;
    take_idle = 1'b0;
    repeat (40) send_item(in_item_t'{16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    repeat (40) send_item(in_item_t'{16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
    send_idle = 1'b1;
    take_idle = 1'b1;
    repeat (40) send_item(random_sample());
    drain();

    repeat (6) @(posedge clk);
    if (cmd_model.mismatches == 0 && cmd_model.due_cmds.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### dual_pid_speed_heading.f
design/dps_pkg.sv
design/dps_cfg_regs.sv
design/dps_err_stage.sv
design/dps_pid_term.sv
design/dual_pid_speed_heading.sv
bench/dual_pid_speed_heading_test.sv
